/* rtl/prrts_pkg.sv */
// prrts_pkg: shared types and constants of the task scheduler
// no dependencies; imported by all scheduler modules
`timescale 1ns / 1ps
package prrts_pkg;

   typedef enum logic [3:0] {
      CMD_CREATE_USER = 4'd0,
      CMD_CREATE_SYS  = 4'd1,
      CMD_START       = 4'd2,
      CMD_PAUSE       = 4'd3,
      CMD_DELETE      = 4'd4,
      CMD_SLEEP       = 4'd5,
      CMD_WAKE        = 4'd6,
      CMD_TICK        = 4'd7,
      CMD_SWITCH      = 4'd8,
      CMD_QUERY       = 4'd9
   } cmd_type;

   localparam logic [2:0] ST_INACTIVE  = 3'd0;
   localparam logic [2:0] ST_READY     = 3'd1;
   localparam logic [2:0] ST_RUNNING   = 3'd2;
   localparam logic [2:0] ST_BLOCKED   = 3'd3;
   localparam logic [2:0] ST_SUSPENDED = 3'd4;

   localparam logic [1:0] RC_OK      = 2'd0;
   localparam logic [1:0] RC_INVALID = 2'd1;
   localparam logic [1:0] RC_BUSY    = 2'd2;
   localparam logic [1:0] RC_FULL    = 2'd3;

   localparam logic [1:0] CSR_RUNNING  = 2'd0;
   localparam logic [1:0] CSR_PRIO_MIN = 2'd1;
   localparam logic [1:0] CSR_PRIO_MAX = 2'd2;

   localparam logic [31:0] FOREVER = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [3:0]  cmd;
      logic [31:0] target_id;
      logic        self_target;
      logic [4:0]  priority_req;
      logic [31:0] ticks;
      logic        in_isr;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] result_id;
      logic [2:0]  slot_index;
      logic        idle_selected;
      logic [2:0]  task_state;
      logic        switch_request;
   } rsp_type;

   // decoded command handed from front to back
   typedef struct packed {
      req_type     req;
      logic        valid_cmd;
      logic        prio_bad;
   } job_type;

   typedef enum logic [2:0] {
      EX_IDLE,
      EX_SCAN,
      EX_PICK,
      EX_APPLY,
      EX_DONE
   } ex_state_type;

endpackage

/* rtl/priority_round_robin_task_scheduler.sv */
// channel  ports                         beat moves when
// req      req_push req_full req_data    req_push && !req_full
// rsp      rsp_empty rsp_pop rsp_data    rsp_pop && !rsp_empty
// csr      csr_we csr_index csr_data     csr_we
// each command walks the table one slot a cycle in prrts_exec: a scan, then for a
// switch a second pick walk, then an apply step and a done step.
// a two-beat queue ahead of the sequencer takes commands while it works.
// synchronous reset clears all slots, the queue and the result register.
`timescale 1ns / 1ps
module priority_round_robin_task_scheduler
   import prrts_pkg::*;
#(
   parameter int MAX_TASKS    = 8,
   parameter int MAX_PRIORITY = 31
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  req_type    req_data,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output rsp_type    rsp_data,
   input  logic       csr_we,
   input  logic [1:0] csr_index,
   input  logic [4:0] csr_data
);

   logic       run_ff;
   logic [4:0] pmin_ff, pmax_ff;
   logic       job_valid, job_take, rsp_valid;
   job_type    job;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         pmin_ff <= 5'd1;
         pmax_ff <= 5'd30;
      end else if (csr_we) begin
         case (csr_index)
            CSR_RUNNING:  run_ff  <= csr_data[0];
            CSR_PRIO_MIN: pmin_ff <= csr_data;
            CSR_PRIO_MAX: pmax_ff <= csr_data;
            default: ;
         endcase
      end
   end

   prrts_front #(.MAX_PRIORITY(MAX_PRIORITY)) u_front (
      .clock, .reset, .push(req_push), .full(req_full), .req(req_data),
      .prio_min(pmin_ff), .prio_max(pmax_ff),
      .job_valid, .job_take, .job
   );

   prrts_exec #(.MAX_TASKS(MAX_TASKS)) u_exec (
      .clock, .reset, .job_valid, .job_take, .job, .running(run_ff),
      .rsp_valid, .rsp_take(rsp_pop), .rsp(rsp_data)
   );

   assign rsp_empty = !rsp_valid;

endmodule

/* rtl/prrts_front.sv */
// prrts_front: accepts commands, checks command code and create priority
// depends on prrts_pkg; feeds a two-entry queue to prrts_exec
`timescale 1ns / 1ps
module prrts_front
   import prrts_pkg::*;
#(
   parameter int MAX_PRIORITY = 31
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  req_type req,
   input  logic [4:0] prio_min,
   input  logic [4:0] prio_max,
   output logic    job_valid,
   input  logic    job_take,
   output job_type job
);

   job_type     q_ff [2];
   job_type     q_in [2];
   logic [1:0]  cnt_ff, cnt_in;
   logic        rd_ff, rd_in;
   job_type     dec;
   logic        do_push;

   always_comb begin
      dec           = '0;
      dec.req       = req;
      dec.valid_cmd = (req.cmd <= 4'(CMD_QUERY));
      dec.prio_bad  = ((req.cmd == 4'(CMD_CREATE_USER)) &&
                       ((req.priority_req < prio_min) || (req.priority_req > prio_max)))
                   || (32'(req.priority_req) > 32'(MAX_PRIORITY));
   end

   assign full      = (cnt_ff == 2'd2);
   assign do_push   = push && !full;
   assign job_valid = (cnt_ff != 2'd0);
   assign job       = q_ff[rd_ff];

   always_comb begin
      q_in   = q_ff;
      cnt_in = cnt_ff;
      rd_in  = rd_ff;
      if (job_take && job_valid) begin
         rd_in = ~rd_ff;
      end
      // write slot sits behind the waiting entries, whatever leaves this cycle
      if (do_push) begin
         q_in[rd_ff ^ (cnt_ff != 2'd0)] = dec;
      end
      cnt_in = cnt_ff + 2'(do_push) - 2'(job_take && job_valid);
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      if (reset) begin
         cnt_ff <= '0;
         rd_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff  <= rd_in;
      end
   end

endmodule

/* rtl/prrts_exec.sv */
// prrts_exec: slot table and sequencer that carries out one command
// depends on prrts_pkg; job from prrts_front, result into output register
`timescale 1ns / 1ps
module prrts_exec
   import prrts_pkg::*;
#(
   parameter int MAX_TASKS = 8
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    job_valid,
   output logic    job_take,
   input  job_type job,
   input  logic    running,
   output logic    rsp_valid,
   input  logic    rsp_take,
   output rsp_type rsp
);

   localparam int SW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int CW = $clog2(MAX_TASKS + 2);
   localparam logic [CW-1:0] CUR_IDLE = CW'(MAX_TASKS);
   localparam logic [CW-1:0] CUR_NONE = CW'(MAX_TASKS + 1);

   logic          used_ff  [MAX_TASKS];
   logic [31:0]   id_ff    [MAX_TASKS];
   logic [4:0]    prio_ff  [MAX_TASKS];
   logic [31:0]   delay_ff [MAX_TASKS];
   logic [2:0]    st_ff    [MAX_TASKS];
   logic [CW-1:0] cur_ff;
   logic [SW-1:0] rr_ff;
   logic [31:0]   idc_ff;

   ex_state_type  state_ff, state_in;
   logic [SW:0]   i_ff, i_in;
   logic          hit_ff;          // scan found something
   logic [SW-1:0] hs_ff;           // slot found by scan
   logic          bf_ff;           // ready seen
   logic [4:0]    best_ff;
   logic [SW-1:0] cand_ff;
   logic          rv_ff;
   rsp_type       r_ff;

   req_type       q;
   logic [SW-1:0] idx, rri;
   logic          rdy_i;
   logic          cur_is_slot;
   logic [SW-1:0] cur_s;
   rsp_type       r;
   logic          cmd_lookup;

   assign q           = job.req;
   assign idx         = i_ff[SW-1:0];
   assign cur_is_slot = (cur_ff < CW'(MAX_TASKS));
   assign cur_s       = cur_ff[SW-1:0];
   assign rsp_valid   = rv_ff;
   assign rsp         = r_ff;
   assign job_take    = (state_ff == EX_DONE);
   assign cmd_lookup  = (q.cmd == 4'(CMD_START)) || (q.cmd == 4'(CMD_PAUSE))
                     || (q.cmd == 4'(CMD_DELETE)) || (q.cmd == 4'(CMD_WAKE))
                     || (q.cmd == 4'(CMD_QUERY));

   // round-robin index: slot after pointer, plus step
   always_comb begin
      logic [SW:0] t;
      t   = {1'b0, rr_ff} + 1'b1 + i_ff;
      rri = (t >= (SW+1)'(MAX_TASKS)) ? SW'(t - (SW+1)'(MAX_TASKS)) : t[SW-1:0];
   end
   // preempted running task counts as ready during a switch
   assign rdy_i = used_ff[rri] && ((st_ff[rri] == ST_READY) ||
                  (cur_is_slot && rri == cur_s && st_ff[rri] == ST_RUNNING));

   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      unique case (state_ff)
         EX_IDLE: begin
            i_in = '0;
            if (job_valid && !rv_ff) state_in = EX_SCAN;
         end
         EX_SCAN: begin
            i_in = i_ff + 1'b1;
            if (i_ff == (SW+1)'(MAX_TASKS - 1)) begin
               i_in     = '0;
               state_in = (q.cmd == 4'(CMD_SWITCH)) ? EX_PICK : EX_APPLY;
            end
         end
         EX_PICK: begin
            i_in = i_ff + 1'b1;
            if (i_ff == (SW+1)'(MAX_TASKS - 1)) state_in = EX_APPLY;
         end
         EX_APPLY: state_in = EX_DONE;
         EX_DONE:  state_in = EX_IDLE;
         default:  state_in = EX_IDLE;
      endcase
   end

   // result of the apply step
   always_comb begin
      logic [SW-1:0] s;
      logic          ok;
      r  = '0;
      s  = hs_ff;
      ok = hit_ff && (q.target_id != 32'd0);
      if (!job.valid_cmd) begin
         r.status = RC_INVALID;
      end else begin
         case (q.cmd)
            4'(CMD_CREATE_USER), 4'(CMD_CREATE_SYS): begin
               if (job.prio_bad) r.status = RC_INVALID;
               else if (!hit_ff) r.status = RC_FULL;
               else begin
                  r.result_id  = idc_ff;
                  r.slot_index = 3'(hs_ff);
               end
            end
            4'(CMD_START): begin
               if (!ok) r.status = RC_INVALID;
               else r.switch_request = running;
            end
            4'(CMD_PAUSE), 4'(CMD_DELETE): begin
               if (q.self_target) begin
                  if (cur_ff == CUR_IDLE) r.status = RC_BUSY;
                  else if (!cur_is_slot || !used_ff[cur_s]) r.status = RC_INVALID;
                  else r.switch_request = running;
               end else if (!ok) r.status = RC_INVALID;
               else if (q.cmd == 4'(CMD_PAUSE))
                  r.switch_request = cur_is_slot && s == cur_s && running;
               else
                  r.switch_request = cur_is_slot && s == cur_s && running;
            end
            4'(CMD_SLEEP): begin
               r.switch_request = (q.ticks != 0) && running && !q.in_isr && cur_is_slot;
            end
            4'(CMD_WAKE): begin
               r.switch_request = ok && st_ff[s] == ST_BLOCKED && running;
            end
            4'(CMD_SWITCH): begin
               r.idle_selected = !bf_ff;
               if (bf_ff) begin
                  r.result_id  = id_ff[cand_ff];
                  r.slot_index = 3'(cand_ff);
               end
            end
            4'(CMD_QUERY): begin
               if (q.self_target) begin
                  if (cur_ff == CUR_IDLE) r.task_state = ST_RUNNING;
                  else if (cur_is_slot) r.task_state = st_ff[cur_s];
               end else if (ok) r.task_state = st_ff[s];
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      logic [SW-1:0] s;
      if (reset) begin
         state_ff <= EX_IDLE;
         i_ff     <= '0;
         rv_ff    <= 1'b0;
         cur_ff   <= CUR_NONE;
         rr_ff    <= '0;
         idc_ff   <= 32'd1;
         for (int k = 0; k < MAX_TASKS; k++) begin
            used_ff[k]  <= 1'b0;
            id_ff[k]    <= '0;
            prio_ff[k]  <= '0;
            delay_ff[k] <= '0;
            st_ff[k]    <= ST_INACTIVE;
         end
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         if (rsp_take && rv_ff) rv_ff <= 1'b0;
         unique case (state_ff)
            EX_IDLE: begin
               hit_ff <= 1'b0;
               hs_ff  <= '0;
               bf_ff  <= 1'b0;
               best_ff <= '0;
               cand_ff <= '0;
            end
            EX_SCAN: begin
               // one slot a cycle: lookup, free search, tick ageing, best priority
               if (!hit_ff) begin
                  if ((q.cmd == 4'(CMD_CREATE_USER) || q.cmd == 4'(CMD_CREATE_SYS))
                      && !used_ff[idx]) begin
                     hit_ff <= 1'b1; hs_ff <= idx;
                  end
                  if (cmd_lookup && used_ff[idx] && id_ff[idx] == q.target_id) begin
                     hit_ff <= 1'b1; hs_ff <= idx;
                  end
               end
               if (q.cmd == 4'(CMD_TICK) && q.ticks != 0 && used_ff[idx] &&
                   st_ff[idx] == ST_BLOCKED && delay_ff[idx] != FOREVER) begin
                  if (delay_ff[idx] > q.ticks) delay_ff[idx] <= delay_ff[idx] - q.ticks;
                  else begin
                     delay_ff[idx] <= '0;
                     st_ff[idx]    <= ST_READY;
                  end
               end
               if (rdy_i && (!bf_ff || prio_ff[rri] > best_ff)) begin
                  bf_ff   <= 1'b1;
                  best_ff <= prio_ff[rri];
               end
            end
            EX_PICK: begin
               if (!hit_ff && rdy_i && prio_ff[rri] == best_ff) begin
                  hit_ff  <= 1'b1;
                  cand_ff <= rri;
               end
            end
            EX_APPLY: begin
               rv_ff <= 1'b1;
               r_ff  <= r;
               s = hs_ff;
               if (job.valid_cmd) begin
                  case (q.cmd)
                     4'(CMD_CREATE_USER), 4'(CMD_CREATE_SYS): begin
                        if (!job.prio_bad && hit_ff) begin
                           used_ff[s]  <= 1'b1;
                           id_ff[s]    <= idc_ff;
                           prio_ff[s]  <= q.priority_req;
                           delay_ff[s] <= '0;
                           st_ff[s]    <= ST_SUSPENDED;
                           idc_ff <= (idc_ff == FOREVER) ? 32'd1 : idc_ff + 32'd1;
                        end
                     end
                     4'(CMD_START): begin
                        if (hit_ff && q.target_id != 0) begin
                           delay_ff[s] <= '0;
                           st_ff[s]    <= ST_READY;
                        end
                     end
                     4'(CMD_PAUSE), 4'(CMD_DELETE): begin
                        if (q.self_target) s = cur_s;
                        if ((q.self_target && cur_is_slot && used_ff[cur_s]) ||
                            (!q.self_target && hit_ff && q.target_id != 0)) begin
                           delay_ff[s] <= '0;
                           if (q.cmd == 4'(CMD_PAUSE)) st_ff[s] <= ST_SUSPENDED;
                           else begin
                              used_ff[s] <= 1'b0;
                              id_ff[s]   <= '0;
                              prio_ff[s] <= '0;
                              st_ff[s]   <= ST_INACTIVE;
                              if (cur_is_slot && s == cur_s) cur_ff <= CUR_NONE;
                           end
                        end
                     end
                     4'(CMD_SLEEP): begin
                        if (q.ticks != 0 && running && !q.in_isr && cur_is_slot) begin
                           delay_ff[cur_s] <= q.ticks;
                           st_ff[cur_s]    <= ST_BLOCKED;
                        end
                     end
                     4'(CMD_WAKE): begin
                        if (hit_ff && q.target_id != 0 && st_ff[s] == ST_BLOCKED) begin
                           delay_ff[s] <= '0;
                           st_ff[s]    <= ST_READY;
                        end
                     end
                     4'(CMD_SWITCH): begin
                        // a re-picked current task simply stays running
                        if (cur_is_slot && st_ff[cur_s] == ST_RUNNING &&
                            !(bf_ff && cand_ff == cur_s))
                           st_ff[cur_s] <= ST_READY;
                        if (bf_ff) begin
                           rr_ff          <= cand_ff;
                           st_ff[cand_ff] <= ST_RUNNING;
                           cur_ff         <= CW'(cand_ff);
                        end else begin
                           cur_ff <= CUR_IDLE;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            EX_DONE: ;
            default: ;
         endcase
      end
   end

endmodule

/* rtl/prrts_checker.sv */
// prrts_checker: port-level checks of the scheduler
// depends on prrts_pkg; bound to priority_round_robin_task_scheduler
`timescale 1ns / 1ps
module prrts_checker
   import prrts_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_push,
   input logic    req_full,
   input logic    rsp_empty,
   input logic    rsp_pop,
   input rsp_type rsp_data
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_empty == 1'b0 && !rsp_pop |=> !rsp_empty && $stable(rsp_data))
      else $error("result beat changed while waiting");

   a_idle_id: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_data.idle_selected |-> rsp_data.result_id == 32'd0)
      else $error("idle pick with nonzero id");

   a_sw_ok: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_data.switch_request |-> rsp_data.status == RC_OK)
      else $error("switch request on failed command");

   a_rst: assert property (@(posedge clock) $past(reset) |-> rsp_empty && !req_full)
      else $error("not empty after reset");

endmodule

bind priority_round_robin_task_scheduler prrts_checker u_checker (
   .clock, .reset, .req_push, .req_full, .rsp_empty, .rsp_pop, .rsp_data
);

/* sim/tb_priority_round_robin_task_scheduler.sv */
// testbench for the priority round-robin task scheduler: random and directed commands
// checked beat by beat against an in-bench model of the slot table; needs prrts_pkg and the rtl
`timescale 1ns / 1ps
module tb_priority_round_robin_task_scheduler;
   import prrts_pkg::*;

   localparam int NSLOT = 8;
   localparam int PRIO_TOP = 31;
   localparam logic [3:0] CUR_IDLE = 4'd8;
   localparam logic [3:0] CUR_NONE = 4'd9;
   localparam int CYCLE_LIMIT = 1200000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   req_type req_data = '0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [1:0] csr_index = CSR_RUNNING;
   logic [4:0] csr_data = '0;

   priority_round_robin_task_scheduler i_dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_data(req_data),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // scheduler model state
   logic        kern_on;
   logic [4:0]  umin, umax;
   logic        s_used [NSLOT];
   logic [31:0] s_id [NSLOT];
   logic [4:0]  s_prio [NSLOT];
   logic [31:0] s_delay [NSLOT];
   logic [2:0]  s_state [NSLOT];
   logic [3:0]  cur_task;
   logic [2:0]  rr_ptr;
   logic [31:0] next_id;

   req_type cmd_queue [$];
   rsp_type expected_rsp [$];
   int mismatches = 0;
   int cycles = 0;
   int send_idle = 0, recv_stall = 0;

   function automatic int find_slot(logic [31:0] id);
      for (int i = 0; i < NSLOT; i++)
         if (s_used[i] && s_id[i] == id) return i;
      return NSLOT;
   endfunction

   function automatic rsp_type schedule_step(req_type r);
      rsp_type o;
      int s;
      bit found;
      logic [4:0] best;
      o = '0;
      o.status = RC_OK;
      case (r.cmd)
         CMD_CREATE_USER, CMD_CREATE_SYS: begin
            if ((r.cmd == CMD_CREATE_USER && (r.priority_req < umin || r.priority_req > umax))
                || r.priority_req > PRIO_TOP) begin
               o.status = RC_INVALID;
            end else begin
               o.status = RC_FULL;
               for (int i = 0; i < NSLOT; i++) begin
                  if (!s_used[i]) begin
                     s_used[i] = 1; s_id[i] = next_id; s_prio[i] = r.priority_req;
                     s_delay[i] = 0; s_state[i] = ST_SUSPENDED;
                     o.result_id = next_id; o.slot_index = 3'(i); o.status = RC_OK;
                     next_id++;
                     if (next_id == 0) next_id = 1;
                     break;
                  end
               end
            end
         end
         CMD_START: begin
            s = (r.target_id == 0) ? NSLOT : find_slot(r.target_id);
            if (s >= NSLOT) o.status = RC_INVALID;
            else begin
               s_delay[s] = 0; s_state[s] = ST_READY; o.switch_request = kern_on;
            end
         end
         CMD_PAUSE, CMD_DELETE: begin
            if (r.self_target && cur_task == CUR_IDLE) o.status = RC_BUSY;
            else begin
               if (r.self_target) s = int'(cur_task);
               else s = (r.target_id == 0) ? NSLOT : find_slot(r.target_id);
               if (s >= NSLOT || !s_used[s]) o.status = RC_INVALID;
               else if (r.cmd == CMD_PAUSE) begin
                  s_delay[s] = 0; s_state[s] = ST_SUSPENDED;
                  if (s == cur_task && kern_on) o.switch_request = 1;
               end else begin
                  s_used[s] = 0; s_id[s] = 0; s_prio[s] = 0; s_delay[s] = 0;
                  s_state[s] = ST_INACTIVE;
                  if (s == cur_task) begin
                     cur_task = CUR_NONE; o.switch_request = kern_on;
                  end
               end
            end
         end
         CMD_SLEEP: begin
            if (r.ticks != 0 && kern_on && !r.in_isr && cur_task < NSLOT) begin
               s_delay[cur_task] = r.ticks; s_state[cur_task] = ST_BLOCKED;
               o.switch_request = 1;
            end
         end
         CMD_WAKE: begin
            if (r.target_id != 0) begin
               s = find_slot(r.target_id);
               if (s < NSLOT && s_state[s] == ST_BLOCKED) begin
                  s_delay[s] = 0; s_state[s] = ST_READY; o.switch_request = kern_on;
               end
            end
         end
         CMD_TICK: begin
            if (r.ticks != 0)
               for (int i = 0; i < NSLOT; i++) begin
                  if (!s_used[i] || s_state[i] != ST_BLOCKED || s_delay[i] == FOREVER) continue;
                  if (s_delay[i] > r.ticks) s_delay[i] -= r.ticks;
                  else begin
                     s_delay[i] = 0; s_state[i] = ST_READY;
                  end
               end
         end
         CMD_SWITCH: begin
            found = 0; best = 0;
            if (cur_task < NSLOT && s_state[cur_task] == ST_RUNNING)
               s_state[cur_task] = ST_READY;
            for (int i = 0; i < NSLOT; i++)
               if (s_used[i] && s_state[i] == ST_READY && (!found || s_prio[i] > best)) begin
                  best = s_prio[i]; found = 1;
               end
            o.idle_selected = 1;
            if (found)
               for (int k = 1; k <= NSLOT; k++) begin
                  s = (int'(rr_ptr) + k) % NSLOT;
                  if (s_used[s] && s_state[s] == ST_READY && s_prio[s] == best) begin
                     rr_ptr = 3'(s); s_state[s] = ST_RUNNING; cur_task = 4'(s);
                     o.result_id = s_id[s]; o.slot_index = 3'(s); o.idle_selected = 0;
                     break;
                  end
               end
            if (o.idle_selected) cur_task = CUR_IDLE;
         end
         CMD_QUERY: begin
            if (r.self_target) begin
               if (cur_task == CUR_IDLE) o.task_state = ST_RUNNING;
               else if (cur_task < NSLOT) o.task_state = s_state[cur_task];
            end else if (r.target_id != 0) begin
               s = find_slot(r.target_id);
               if (s < NSLOT) o.task_state = s_state[s];
            end
         end
         default: o.status = RC_INVALID;
      endcase
      return o;
   endfunction

   // driver
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (reset) req_push <= 1'b0;
      else if (req_push && !req_full) begin
         expected_rsp.push_back(schedule_step(req_data));
         void'(cmd_queue.pop_front());
         if (cmd_queue.size() > 0 && $urandom_range(99) >= send_idle) begin
            req_data <= cmd_queue[0]; req_push <= 1'b1;
         end else req_push <= 1'b0;
      end else if (!req_push && cmd_queue.size() > 0 && $urandom_range(99) >= send_idle) begin
         req_data <= cmd_queue[0]; req_push <= 1'b1;
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_type e;
      if (!reset) begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_rsp.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected beat %p", rsp_data);
            end else begin
               e = expected_rsp.pop_front();
               if (rsp_data !== e) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected %p got %p", e, rsp_data);
               end
            end
         end
         rsp_pop <= ($urandom_range(99) >= recv_stall);
      end
   end

   always @(posedge clock)
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_priority_round_robin_task_scheduler NOT OK");
         $finish;
      end

   task automatic write_reg(logic [1:0] idx, logic [4:0] val);
      @(posedge clock);
      csr_we <= 1'b1; csr_index <= idx; csr_data <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_RUNNING:  kern_on = val[0];
         CSR_PRIO_MIN: umin = val;
         default:      umax = val;
      endcase
   endtask

   task automatic drain;
      while (cmd_queue.size() > 0 || expected_rsp.size() > 0 || req_push) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_id();
      int k;
      k = $urandom_range(9);
      if (k == 0) return 0;
      if (k == 1) return $urandom;
      if (k == 2) return next_id;
      return s_id[$urandom_range(NSLOT - 1)] + (($urandom_range(7) == 0) ? 1 : 0);
   endfunction

   function automatic req_type rand_cmd();
      req_type r;
      int k;
      r = '0;
      k = $urandom_range(99);
      if (k < 2) r.cmd = 4'(10 + $urandom_range(5));
      else if (k < 14) r.cmd = CMD_CREATE_USER;
      else if (k < 20) r.cmd = CMD_CREATE_SYS;
      else if (k < 32) r.cmd = CMD_START;
      else if (k < 40) r.cmd = CMD_PAUSE;
      else if (k < 47) r.cmd = CMD_DELETE;
      else if (k < 56) r.cmd = CMD_SLEEP;
      else if (k < 62) r.cmd = CMD_WAKE;
      else if (k < 72) r.cmd = CMD_TICK;
      else if (k < 90) r.cmd = CMD_SWITCH;
      else r.cmd = CMD_QUERY;
      r.target_id = rand_id();
      r.self_target = 1'($urandom_range(1));
      r.priority_req = ($urandom_range(3) == 0) ? 5'($urandom_range(31))
                                                : 5'($urandom_range(4) + 1);
      k = $urandom_range(9);
      r.ticks = (k == 0) ? 0 : (k == 1) ? FOREVER : (k == 2) ? $urandom : $urandom_range(20);
      r.in_isr = ($urandom_range(7) == 0);
      return r;
   endfunction

   initial begin
      req_type r;
      kern_on = 0; umin = 1; umax = 30;
      for (int i = 0; i < NSLOT; i++) begin
         s_used[i] = 0; s_id[i] = 0; s_prio[i] = 0; s_delay[i] = 0; s_state[i] = ST_INACTIVE;
      end
      cur_task = CUR_NONE; rr_ptr = 0; next_id = 1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: stopped kernel, priority bounds, fill table, unknown codes
      r = '0;
      r.cmd = CMD_QUERY; r.self_target = 1; cmd_queue.push_back(r);
      r.cmd = CMD_PAUSE; cmd_queue.push_back(r);
      r.cmd = CMD_CREATE_USER; r.priority_req = 0; cmd_queue.push_back(r);
      r.priority_req = 31; cmd_queue.push_back(r);
      r.cmd = CMD_CREATE_SYS; cmd_queue.push_back(r);
      r.priority_req = 0; cmd_queue.push_back(r);
      for (int i = 0; i < 7; i++) begin
         r.cmd = CMD_CREATE_USER; r.priority_req = 5'(1 + i % 3); cmd_queue.push_back(r);
      end
      r.cmd = CMD_START; r.target_id = 0; cmd_queue.push_back(r);
      r.target_id = 3; cmd_queue.push_back(r);
      r.cmd = CMD_SWITCH; cmd_queue.push_back(r);
      r.cmd = CMD_SLEEP; r.ticks = 5; cmd_queue.push_back(r);
      r.cmd = CMD_TICK; r.ticks = 32'hFFFF_FFFF; cmd_queue.push_back(r);
      r.cmd = CMD_DELETE; r.self_target = 1; cmd_queue.push_back(r);
      r.cmd = 4'd15; r.target_id = 32'hFFFF_FFFF; r.priority_req = 5'h1f;
      r.in_isr = 1; cmd_queue.push_back(r);
      r.cmd = CMD_SWITCH; cmd_queue.push_back(r);
      r.cmd = CMD_DELETE; cmd_queue.push_back(r);
      drain();
      write_reg(CSR_RUNNING, 5'd1);

      for (int ph = 0; ph < 8; ph++) begin
         send_idle = (ph % 4 == 1 || ph % 4 == 3) ? 75 : 0;
         recv_stall = (ph % 4 == 2 || ph % 4 == 3) ? 75 : 0;
         if (ph % 4 == 3) begin
            send_idle = 13; recv_stall = 13;
         end
         for (int n = 0; n < 190; n++) cmd_queue.push_back(rand_cmd());
         drain();
         case (ph)
            1: write_reg(CSR_PRIO_MIN, 5'd0);
            2: write_reg(CSR_PRIO_MAX, 5'd31);
            3: write_reg(CSR_RUNNING, 5'd0);
            4: begin
               write_reg(CSR_RUNNING, 5'd1); write_reg(CSR_PRIO_MIN, 5'd3);
               write_reg(CSR_PRIO_MAX, 5'd2);
            end
            5: begin
               write_reg(CSR_PRIO_MIN, 5'd31); write_reg(CSR_PRIO_MAX, 5'd31);
            end
            6: begin
               write_reg(CSR_PRIO_MIN, 5'd1); write_reg(CSR_PRIO_MAX, 5'd30);
            end
            default: ;
         endcase
      end
      if (mismatches == 0) $display("tb_priority_round_robin_task_scheduler OK");
      else $display("tb_priority_round_robin_task_scheduler NOT OK");
      $finish;
   end
endmodule
